// ===== src/mts_pkg.sv =====
`default_nettype none

package mts_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [DATA_W-1:0] EMPTY_WORD = {DATA_W{1'b1}};

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctrl_t;

endpackage

`default_nettype wire

// ===== src/mts_cell.sv =====
`default_nettype none

module mts_cell
    import mts_pkg::*;
(
    input  wire logic               clk,
    input  wire shift_ctrl_t        ctrl,
    input  wire logic [DATA_W-1:0]  from_up,
    input  wire logic [DATA_W-1:0]  from_down,
    output logic      [DATA_W-1:0]  data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push)
        begin
            data_next = from_up;
        end
        else if (ctrl.pop)
        begin
            data_next = from_down;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== src/mts_chain.sv =====
`default_nettype none

module mts_chain
    import mts_pkg::*;
(
    input  wire logic               clk,
    input  wire shift_ctrl_t        ctrl,
    input  wire logic [DATA_W-1:0]  push_data,
    output logic      [DATA_W-1:0]  head
);

    logic [DATA_W-1:0] cell_data [STACK_DEPTH];

    // cell 0 is the top of stack; push shifts away from it, pop towards it
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] up_data;
        logic [DATA_W-1:0] down_data;

        if (i == 0)
        begin : g_first
            assign up_data = push_data;
        end
        else
        begin : g_mid
            assign up_data = cell_data[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign down_data = cell_data[i];
        end
        else
        begin : g_inner
            assign down_data = cell_data[i+1];
        end

        mts_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .from_up   (up_data),
            .from_down (down_data),
            .data      (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

`default_nettype wire

// ===== src/min_tracking_stack_core.sv =====
// Result beat is valid in the cycle after the input beat is accepted.
// Throughput: one item per cycle unless out_ready stalls the output; value
// cells all shift on an accepted push or pop, minimum cells only on a change.
// Reset: entry counts, output valid and rejected cleared asynchronously; cell
// contents are left uninitialised and need no clearing pass.
`default_nettype none

module min_tracking_stack_core
    import mts_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      kind,
    input  wire logic signed [DATA_W-1:0]  value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed      [DATA_W-1:0]  top_value,
    output logic signed      [DATA_W-1:0]  min_value,
    output logic                           is_empty,
    output logic                           rejected
);

    logic [CNT_W-1:0] value_count_reg,   value_count_next;
    logic [CNT_W-1:0] minimum_count_reg, minimum_count_next;
    logic             out_valid_reg,     out_valid_next;
    logic             rejected_reg,      rejected_next;

    logic [DATA_W-1:0] val_head;
    logic [DATA_W-1:0] min_head;

    logic        take_item;
    logic        val_full;
    logic        val_empty;
    logic        min_empty;
    logic        push_ok;
    logic        pop_ok;
    shift_ctrl_t val_ctrl;
    shift_ctrl_t min_ctrl;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take_item = in_valid && in_ready;

    assign val_full  = (value_count_reg == CNT_W'(STACK_DEPTH));
    assign val_empty = (value_count_reg == '0);
    assign min_empty = (minimum_count_reg == '0);

    assign push_ok = take_item && (kind == KIND_PUSH) && !val_full;
    assign pop_ok  = take_item && (kind == KIND_POP) && !val_empty;

    assign val_ctrl.push = push_ok;
    assign val_ctrl.pop  = pop_ok;
    assign min_ctrl.push = push_ok && (min_empty || (value <= $signed(min_head)));
    assign min_ctrl.pop  = pop_ok && (val_head == min_head);

    mts_chain u_val_chain (
        .clk       (clk),
        .ctrl      (val_ctrl),
        .push_data (value),
        .head      (val_head)
    );

    mts_chain u_min_chain (
        .clk       (clk),
        .ctrl      (min_ctrl),
        .push_data (value),
        .head      (min_head)
    );

    always_comb
    begin
        value_count_next   = value_count_reg;
        minimum_count_next = minimum_count_reg;
        rejected_next      = rejected_reg;
        out_valid_next     = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (val_ctrl.push)
        begin
            value_count_next = value_count_reg + CNT_W'(1);
        end
        else if (val_ctrl.pop)
        begin
            value_count_next = value_count_reg - CNT_W'(1);
        end

        if (min_ctrl.push)
        begin
            minimum_count_next = minimum_count_reg + CNT_W'(1);
        end
        else if (min_ctrl.pop)
        begin
            minimum_count_next = minimum_count_reg - CNT_W'(1);
        end

        if (take_item)
        begin
            out_valid_next = 1'b1;
            rejected_next  = !(push_ok || pop_ok);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_count_reg   <= '0;
            minimum_count_reg <= '0;
            out_valid_reg     <= 1'b0;
            rejected_reg      <= 1'b0;
        end
        else
        begin
            value_count_reg   <= value_count_next;
            minimum_count_reg <= minimum_count_next;
            out_valid_reg     <= out_valid_next;
            rejected_reg      <= rejected_next;
        end
    end

    // heads and counts only move on an accepted beat, so these hold while stalled
    assign out_valid = out_valid_reg;
    assign is_empty  = val_empty;
    assign rejected  = rejected_reg;
    assign top_value = val_empty ? EMPTY_WORD : val_head;
    assign min_value = min_empty ? EMPTY_WORD : min_head;

`ifndef ASSERT_OFF
    a_min_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        minimum_count_reg <= value_count_reg)
        else $error("minimum stack deeper than value stack");

    a_min_present: assert property (@(posedge clk) disable iff (!rst_n)
        !val_empty |-> !min_empty)
        else $error("minimum stack empty while values remain");

    a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
        value_count_reg <= CNT_W'(STACK_DEPTH))
        else $error("value count beyond stack depth");

    a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> (top_value == $past(value)) && !rejected && out_valid)
        else $error("pushed beat not at top of stack");

    a_min_not_above_top: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> $signed(min_value) <= $signed(top_value))
        else $error("minimum above top after push");
`endif

endmodule

`default_nettype wire
